>>> src/xtea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

	localparam int MAX_ROUNDS = 64;
	localparam int CNT_W      = $clog2(MAX_ROUNDS + 1);
	localparam int LATENCY    = 2 * MAX_ROUNDS + 1;
	localparam int IDX_W      = 3;
	localparam int RC_W       = 7;

	localparam logic [IDX_W-1:0] REG_KEY0   = 3'd0;
	localparam logic [IDX_W-1:0] REG_KEY1   = 3'd1;
	localparam logic [IDX_W-1:0] REG_KEY2   = 3'd2;
	localparam logic [IDX_W-1:0] REG_KEY3   = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROUNDS = 3'd4;
	localparam logic [IDX_W-1:0] REG_DELTA  = 3'd5;

	localparam logic [RC_W-1:0] RESET_ROUNDS = 7'd32;
	localparam logic [31:0]     RESET_DELTA  = 32'h9E37_79B9;

	typedef struct packed {
		logic        action;
		logic [31:0] word_first;
		logic [31:0] word_second;
	} block_t;

	typedef struct packed {
		logic [31:0] result_first;
		logic [31:0] result_second;
	} result_t;

	typedef struct packed {
		logic        action;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] s;
	} lane_t;

	typedef struct packed {
		logic [3:0][31:0]   key;
		logic [31:0]        delta;
		logic [CNT_W-1:0]   rounds;
	} cfg_t;

	function automatic logic [31:0] mix(input logic [31:0] x);
		return ((x << 4) ^ (x >> 5)) + x;
	endfunction

	function automatic logic [CNT_W-1:0] eff_rounds(input logic [RC_W-1:0] rc);
		logic [7:0] wide;
		wide = {1'b0, rc};
		if (wide > 8'(MAX_ROUNDS)) begin
			return CNT_W'(MAX_ROUNDS);
		end
		return CNT_W'(wide);
	endfunction

endpackage

`default_nettype wire

>>> src/xtea_block_cipher_core.sv
// XTEA block cipher core, 64-bit block, 128-bit key.
// Command channel: a block transfers on a rising edge with start high and
// busy low. busy never rises, so a new block may transfer on every cycle.
// Result channel: done pulses for one cycle with result holding the block;
// the receiver takes it in that cycle and cannot hold it off.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Index 0..3 key words, 4 round count, 5 delta;
// other indexes are ignored. Write only while no block is in flight.
// done is raised for a block once it has passed the entry stage and every
// round cell, whatever the round count; throughput is one block per cycle.
// The block path is a chain of MAX_ROUNDS round cells, each taking two
// register stages, one per half round, behind one entry stage that forms
// the starting sum. Cells beyond the round count pass the block through.
// Reset clears every valid bit and restores the key to zero, the round
// count to 32 and delta to 0x9E3779B9; blocks in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_cipher_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire xtea_pkg::block_t             block,
	output logic                              done,
	output xtea_pkg::result_t                 result,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [xtea_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                  cfg_data
);

	logic [3:0][31:0]             key_q;
	logic [xtea_pkg::RC_W-1:0]    round_count_q;
	logic [31:0]                  delta_q;
	xtea_pkg::cfg_t               cfg;

	logic                         accept;
	logic                         valid_s0;
	xtea_pkg::lane_t              lane_s0;

	logic [xtea_pkg::MAX_ROUNDS:0] chain_valid;
	xtea_pkg::lane_t               chain_lane [xtea_pkg::MAX_ROUNDS+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q         <= '0;
			round_count_q <= xtea_pkg::RESET_ROUNDS;
			delta_q       <= xtea_pkg::RESET_DELTA;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				xtea_pkg::REG_KEY0:   key_q[0]      <= cfg_data;
				xtea_pkg::REG_KEY1:   key_q[1]      <= cfg_data;
				xtea_pkg::REG_KEY2:   key_q[2]      <= cfg_data;
				xtea_pkg::REG_KEY3:   key_q[3]      <= cfg_data;
				xtea_pkg::REG_ROUNDS: round_count_q <= cfg_data[xtea_pkg::RC_W-1:0];
				xtea_pkg::REG_DELTA:  delta_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.key    = key_q;
		cfg.delta  = delta_q;
		cfg.rounds = xtea_pkg::eff_rounds(round_count_q);
	end

	// entry stage: starting sum, delta times round count for decryption, zero for encryption
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		lane_s0.action <= block.action;
		lane_s0.a      <= block.word_first;
		lane_s0.b      <= block.word_second;
		lane_s0.s      <= block.action ? 32'(delta_q * {{(32-xtea_pkg::CNT_W){1'b0}}, cfg.rounds})
		                               : 32'd0;
	end

	assign chain_valid[0] = valid_s0;
	assign chain_lane[0]  = lane_s0;

	for (genvar g = 0; g < xtea_pkg::MAX_ROUNDS; g++) begin : g_cell
		xtea_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg),
			.round_idx (xtea_pkg::CNT_W'(g)),
			.valid_in  (chain_valid[g]),
			.lane_in   (chain_lane[g]),
			.valid_out (chain_valid[g+1]),
			.lane_out  (chain_lane[g+1])
		);
	end

	assign done                 = chain_valid[xtea_pkg::MAX_ROUNDS];
	assign result.result_first  = chain_lane[xtea_pkg::MAX_ROUNDS].a;
	assign result.result_second = chain_lane[xtea_pkg::MAX_ROUNDS].b;

	a_done_has_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, xtea_pkg::LATENCY))
		else $error("result without a matching block transfer");

	a_rounds_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == xtea_pkg::REG_ROUNDS)
		|=> round_count_q == $past(cfg_data[xtea_pkg::RC_W-1:0]))
		else $error("round count register missed a write");

endmodule

`default_nettype wire

>>> src/xtea_round_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module xtea_round_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire xtea_pkg::cfg_t           cfg,
	input  wire logic [xtea_pkg::CNT_W-1:0] round_idx,
	input  wire logic                     valid_in,
	input  wire xtea_pkg::lane_t          lane_in,
	output logic                          valid_out,
	output xtea_pkg::lane_t               lane_out
);

	logic            act;
	logic            enc_a;
	logic [31:0]     x_a;
	logic [31:0]     k_a;
	logic [31:0]     f_a;
	xtea_pkg::lane_t nxt_a;

	logic            valid_s1;
	logic            act_s1;
	xtea_pkg::lane_t lane_s1;

	logic            enc_b;
	logic [31:0]     x_b;
	logic [31:0]     k_b;
	logic [31:0]     f_b;
	xtea_pkg::lane_t nxt_b;

	logic            valid_s2;
	xtea_pkg::lane_t lane_s2;

	// first half round
	always_comb begin
		act   = round_idx < cfg.rounds;
		enc_a = !lane_in.action;
		x_a   = enc_a ? lane_in.b : lane_in.a;
		k_a   = enc_a ? cfg.key[lane_in.s[1:0]] : cfg.key[lane_in.s[12:11]];
		f_a   = xtea_pkg::mix(x_a) ^ (lane_in.s + k_a);
		nxt_a = lane_in;
		if (act) begin
			if (enc_a) begin
				nxt_a.a = lane_in.a + f_a;
				nxt_a.s = lane_in.s + cfg.delta;
			end else begin
				nxt_a.b = lane_in.b - f_a;
				nxt_a.s = lane_in.s - cfg.delta;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= nxt_a;
		act_s1  <= act;
	end

	// second half round
	always_comb begin
		enc_b = !lane_s1.action;
		x_b   = enc_b ? lane_s1.a : lane_s1.b;
		k_b   = enc_b ? cfg.key[lane_s1.s[12:11]] : cfg.key[lane_s1.s[1:0]];
		f_b   = xtea_pkg::mix(x_b) ^ (lane_s1.s + k_b);
		nxt_b = lane_s1;
		if (act_s1) begin
			if (enc_b) begin
				nxt_b.b = lane_s1.b + f_b;
			end else begin
				nxt_b.a = lane_s1.a - f_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		lane_s2 <= nxt_b;
	end

	assign valid_out = valid_s2;
	assign lane_out  = lane_s2;

endmodule

`default_nettype wire
